// File: hdl/pba_pkg.sv
// shared types and constants for the paged bump allocator
`default_nettype none
package pba_pkg;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_PAGES  = 2'd2;
   localparam logic [1:0] ST_LOG_FULL  = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam int SIZE_W = 28;
   localparam int OFF_W  = 27;
   localparam int PAGE_W = 4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_A_RD,
      S_A_END,
      S_A_CHK,
      S_A_NEW,
      S_F_RD,
      S_F_CMP,
      S_F_SHIFT
   } state_type;

endpackage
`default_nettype wire

// File: hdl/pba_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module pba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: hdl/paged_bump_allocator.sv
// top level of the paged bump allocator: sequencer, page counts and block log
// alloc scans the open pages in order and opens a further page if none has room;
// free searches the page's log entries and shifts the later entries down.
// one request in flight; busy stays high until the result strobe cycle,
// in which a new start is already taken. the log lives in one ram (one read, one write port).
// synchronous reset: one page in use, all page logs empty; the receiver cannot stall.
`default_nettype none
module paged_bump_allocator #(
   parameter int MAX_PAGES       = 16,
   parameter int BASE_PAGE_BYTES = 4096,
   parameter int LOG_ENTRIES     = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [pba_pkg::SIZE_W-1:0]    req_alloc_size,
   input  wire logic [pba_pkg::PAGE_W-1:0]    req_free_page,
   input  wire logic [pba_pkg::OFF_W-1:0]     req_free_offset,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [pba_pkg::PAGE_W-1:0]         rsp_page,
   output logic [pba_pkg::OFF_W-1:0]          rsp_offset
);
   import pba_pkg::*;

   localparam int DEPTH   = MAX_PAGES * LOG_ENTRIES;
   localparam int AW      = $clog2(DEPTH);
   localparam int PW      = $clog2(MAX_PAGES + 1);
   localparam int PIW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CW      = $clog2(LOG_ENTRIES + 1);
   localparam int EW_NEED = $clog2(BASE_PAGE_BYTES) + MAX_PAGES + 1;
   localparam int EW      = (EW_NEED > OFF_W + 1) ? EW_NEED : OFF_W + 1;
   localparam int RW      = EW + SIZE_W;

   state_type state_ff, state_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [PW-1:0]      pages_ff, pages_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [EW-1:0]      end_ff, end_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [OFF_W-1:0]   foff_ff;
   logic [CW-1:0]      cnt_ff [MAX_PAGES];

   logic               cnt_we;
   logic [CW-1:0]      cnt_val;
   logic [CW-1:0]      cnt_cur;
   logic               accept;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]  rsp_page_ff, rsp_page_in;
   logic [OFF_W-1:0]   rsp_offset_ff, rsp_offset_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr, base;
   logic [RW-1:0]      wr_data, rd_data;
   logic [EW-1:0]      rd_off;
   logic [SIZE_W-1:0]  rd_size;
   logic [63:0]        cap, sum_a, sum_b;
   logic               fits;

   pba_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_log (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_off  = rd_data[RW-1:SIZE_W];
   assign rd_size = rd_data[SIZE_W-1:0];
   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign cnt_cur = cnt_ff[p_ff[PIW-1:0]];
   assign base    = AW'(p_ff) * AW'(LOG_ENTRIES);
   assign cap     = 64'(BASE_PAGE_BYTES) << p_ff;

   // shared adder and compare
   always_comb begin
      sum_a = 64'(end_ff);
      sum_b = 64'(size_ff);
      if (state_ff == S_A_END) begin
         sum_a = 64'(rd_off);
         sum_b = 64'(rd_size);
      end else if (state_ff == S_A_NEW) begin
         sum_a = 64'd0;
      end
      fits = (sum_a + sum_b) <= cap;
   end

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      pages_in      = pages_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      cnt_we        = 1'b0;
      cnt_val       = cnt_cur;
      wr_en         = 1'b0;
      wr_addr       = base + AW'(idx_ff);
      wr_data       = {end_ff, size_ff};
      rd_addr       = base + AW'(idx_ff);
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_page_in   = '0;
      rsp_offset_in = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
               if (req_type == REQ_ALLOC) begin
                  p_in     = '0;
                  state_in = S_A_RD;
               end else if (PW'(req_free_page) >= pages_ff
                            || 32'(req_free_page) >= 32'(MAX_PAGES)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
               end else begin
                  p_in     = PW'(req_free_page);
                  state_in = S_F_RD;
               end
            end
         end
         S_A_RD: begin
            if (p_ff >= pages_ff) begin
               state_in = S_A_NEW;
            end else if (cnt_cur == '0) begin
               end_in   = '0;
               state_in = S_A_CHK;
            end else begin
               rd_addr  = base + AW'(cnt_cur - CW'(1));
               state_in = S_A_END;
            end
         end
         S_A_END: begin
            end_in   = EW'(sum_a + sum_b);
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            if (fits) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (cnt_cur == CW'(LOG_ENTRIES)) begin
                  rsp_status_in = ST_LOG_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = base + AW'(cnt_cur);
                  cnt_we        = 1'b1;
                  cnt_val       = cnt_cur + CW'(1);
                  rsp_page_in   = PAGE_W'(p_ff);
                  rsp_offset_in = end_ff[OFF_W-1:0];
               end
            end else begin
               p_in     = p_ff + PW'(1);
               state_in = S_A_RD;
            end
         end
         S_A_NEW: begin
            if (32'(p_ff) >= 32'(MAX_PAGES)) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_PAGES;
            end else if (fits) begin
               state_in    = S_IDLE;
               pages_in    = p_ff + PW'(1);
               wr_en       = 1'b1;
               wr_addr     = base;
               wr_data     = {EW'(0), size_ff};
               cnt_we      = 1'b1;
               cnt_val     = CW'(1);
               rsp_valid_in = 1'b1;
               rsp_page_in = PAGE_W'(p_ff);
            end else begin
               p_in = p_ff + PW'(1);
            end
         end
         S_F_RD: begin
            if (idx_ff == cnt_cur) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
            end else begin
               state_in = S_F_CMP;
            end
         end
         S_F_CMP: begin
            if (rd_off == EW'(foff_ff)) begin
               state_in = S_F_SHIFT;
               rd_addr  = base + AW'(idx_ff + CW'(1));
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_F_RD;
            end
         end
         S_F_SHIFT: begin
            // rd_data holds entry idx+1 here
            if (idx_ff + CW'(1) < cnt_cur) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_ff + CW'(1);
               rd_addr = base + AW'(idx_ff + CW'(2));
            end else begin
               cnt_we       = 1'b1;
               cnt_val      = cnt_cur - CW'(1);
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pages_ff     <= PW'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PAGES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pages_ff     <= pages_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            cnt_ff[p_ff[PIW-1:0]] <= cnt_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_offset_ff <= rsp_offset_in;
      if (accept) begin
         size_ff  <= req_alloc_size;
         foff_ff  <= req_free_offset;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_page   = rsp_page_ff;
   assign rsp_offset = rsp_offset_ff;
endmodule
`default_nettype wire

// File: tb/sv/paged_bump_allocator_tb.sv
// testbench for the paged bump allocator: directed and random beats checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module paged_bump_allocator_tb;
   import pba_pkg::*;

   localparam int NUM_PAGES  = 16;
   localparam int PAGE_BASE  = 4096;
   localparam int LOG_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [1:0]        status;
      logic [PAGE_W-1:0] page;
      logic [OFF_W-1:0]  offset;
   } grant_type;

   typedef struct {
      logic [PAGE_W-1:0] page;
      logic [OFF_W-1:0]  offset;
   } block_ref_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_type;
   logic [SIZE_W-1:0] req_alloc_size;
   logic [PAGE_W-1:0] req_free_page;
   logic [OFF_W-1:0]  req_free_offset;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [PAGE_W-1:0] rsp_page;
   logic [OFF_W-1:0]  rsp_offset;

   paged_bump_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_alloc_size(req_alloc_size),
      .req_free_page(req_free_page), .req_free_offset(req_free_offset),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_page(rsp_page), .rsp_offset(rsp_offset)
   );

   // predictor state
   int unsigned  pages_open;
   int unsigned  live_blocks [NUM_PAGES];
   longint unsigned blk_off  [NUM_PAGES][LOG_DEPTH];
   longint unsigned blk_size [NUM_PAGES][LOG_DEPTH];

   grant_type     expected_grants[$];
   block_ref_type live_list[$];
   int         idle_pct;
   int         mismatches;
   int         cycle_count;
   int         alloc_beats, free_beats;
   int         status_seen [4];

   function automatic longint unsigned page_end(int unsigned p);
      if (live_blocks[p] == 0) return 0;
      return blk_off[p][live_blocks[p]-1] + blk_size[p][live_blocks[p]-1];
   endfunction

   function automatic grant_type predict_grant(logic kind, logic [SIZE_W-1:0] size,
                                               logic [PAGE_W-1:0] fpage,
                                               logic [OFF_W-1:0] foff);
      grant_type g;
      longint unsigned fin, cap, remain;
      int unsigned n;
      g.status = ST_OK; g.page = '0; g.offset = '0;
      if (kind == REQ_ALLOC) begin
         for (int unsigned p = 0; p < pages_open; p++) begin
            fin = page_end(p);
            cap = longint'(PAGE_BASE) << p;
            remain = (fin <= cap) ? cap - fin : 0;
            if (remain >= 64'(size)) begin
               n = live_blocks[p];
               if (n >= LOG_DEPTH) begin
                  g.status = ST_LOG_FULL;
                  return g;
               end
               blk_off[p][n] = fin;
               blk_size[p][n] = 64'(size);
               live_blocks[p] = n + 1;
               g.page = PAGE_W'(p);
               g.offset = fin[OFF_W-1:0];
               return g;
            end
         end
         for (int unsigned p = pages_open; p < NUM_PAGES; p++) begin
            if ((longint'(PAGE_BASE) << p) >= 64'(size)) begin
               pages_open = p + 1;
               blk_off[p][0] = 0;
               blk_size[p][0] = 64'(size);
               live_blocks[p] = 1;
               g.page = PAGE_W'(p);
               return g;
            end
         end
         g.status = ST_NO_PAGES;
         return g;
      end
      if (32'(fpage) >= pages_open) begin
         g.status = ST_NOT_FOUND;
         return g;
      end
      n = live_blocks[fpage];
      for (int unsigned j = 0; j < n; j++) begin
         if (blk_off[fpage][j] == 64'(foff)) begin
            for (int unsigned k = j; k + 1 < n; k++) begin
               blk_off[fpage][k] = blk_off[fpage][k+1];
               blk_size[fpage][k] = blk_size[fpage][k+1];
            end
            live_blocks[fpage] = n - 1;
            return g;
         end
      end
      g.status = ST_NOT_FOUND;
      return g;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid) begin
         if (expected_grants.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected result beat status=%0d page=%0d offset=%0d",
                        rsp_status, rsp_page, rsp_offset);
         end else begin
            want = expected_grants.pop_front();
            status_seen[rsp_status] = status_seen[rsp_status] + 1;
            if (rsp_status !== want.status || rsp_page !== want.page ||
                rsp_offset !== want.offset) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch: expected status=%0d page=%0d offset=%0d, got %0d %0d %0d",
                           want.status, want.page, want.offset,
                           rsp_status, rsp_page, rsp_offset);
            end
         end
      end
   end

   task automatic send_beat(logic kind, logic [SIZE_W-1:0] size,
                            logic [PAGE_W-1:0] fpage, logic [OFF_W-1:0] foff);
      grant_type g;
      block_ref_type b;
      start <= 1'b1;
      req_type <= kind;
      req_alloc_size <= size;
      req_free_page <= fpage;
      req_free_offset <= foff;
      do @(posedge clock); while (busy);
      g = predict_grant(kind, size, fpage, foff);
      expected_grants.push_back(g);
      if (kind == REQ_ALLOC) begin
         alloc_beats++;
         if (g.status == ST_OK) begin
            b.page = g.page; b.offset = g.offset;
            live_list.push_back(b);
         end
      end else begin
         free_beats++;
         if (g.status == ST_OK)
            foreach (live_list[i])
               if (live_list[i].page == fpage && live_list[i].offset == foff) begin
                  live_list.delete(i);
                  break;
               end
      end
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic alloc(logic [SIZE_W-1:0] size);
      send_beat(REQ_ALLOC, size, PAGE_W'($urandom), OFF_W'($urandom));
   endtask

   task automatic release_block(logic [PAGE_W-1:0] p, logic [OFF_W-1:0] o);
      send_beat(REQ_FREE, SIZE_W'($urandom), p, o);
   endtask

   task automatic test_directed();
      alloc(28'd0);
      alloc(28'd1);
      release_block(4'd9, 27'd0);
      release_block(4'd0, 27'd5);
      alloc(28'd4096);
      alloc(28'hFFFFFFF);
      release_block(4'd0, 27'd0);
      release_block(4'd0, 27'd0);
      alloc(28'h8000000);
      alloc(28'h8000000);
      alloc(28'd0);
      release_block(4'd15, 27'd0);
      release_block(4'd15, 27'd0);
      release_block(4'd15, 27'h7FFFFFF);
      alloc(28'h8000001);
      alloc(28'h4000000);
      alloc(28'd0);
   endtask

   task automatic test_log_full();
      for (int i = 0; i < LOG_DEPTH + 2; i++) alloc(28'd0);
      while (live_list.size() > 0) release_block(live_list[0].page, live_list[0].offset);
   endtask

   task automatic test_random(int count);
      int r, k;
      logic [SIZE_W-1:0] sz;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (live_list.size() > 150) r = r % 45;
         if (live_list.size() > 0 && r < 45) begin
            k = $urandom_range(live_list.size() - 1);
            release_block(live_list[k].page, live_list[k].offset);
         end else if (r < 88) begin
            k = $urandom_range(99);
            if (k < 70) sz = SIZE_W'($urandom_range(0, 2048));
            else if (k < 95) sz = SIZE_W'($urandom_range(0, 1 << 20));
            else sz = SIZE_W'($urandom);
            alloc(sz);
         end else begin
            release_block(PAGE_W'($urandom), OFF_W'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_ALLOC;
      req_alloc_size = '0;
      req_free_page = '0;
      req_free_offset = '0;
      mismatches = 0;
      cycle_count = 0;
      alloc_beats = 0;
      free_beats = 0;
      status_seen = '{default: 0};
      pages_open = 1;
      live_blocks = '{default: 0};
      idle_pct = 6;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_log_full();
      test_random(500);
      idle_pct = 86;
      test_random(500);
      idle_pct = 0;
      test_log_full();
      test_random(500);
      start <= 1'b0;
      while (expected_grants.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("covered %0d allocate and %0d free beats, %0d pages opened",
               alloc_beats, free_beats, pages_open);
      $display("status counts: ok %0d, not found %0d, no pages %0d, log full %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0 && expected_grants.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

// File: paged_bump_allocator.f
hdl/pba_pkg.sv
hdl/pba_ram.sv
hdl/paged_bump_allocator.sv
tb/sv/paged_bump_allocator_tb.sv
